### rtl/core/c8_pkg.sv
// Shared types, constants and a helper function for the CHIP-8 instruction core.
`default_nettype none
package c8_pkg;
	localparam int MEM_BYTES = 4096;
	localparam int STACK_DEPTH = 16;
	localparam int ADDR_W = 12;
	localparam logic [ADDR_W-1:0] START_RESET = 12'h200;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_EXEC = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_UNDERFLOW = 2'd3;

	localparam logic [1:0] REG_START = 2'd0;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_OR,
		ALU_AND,
		ALU_XOR,
		ALU_PASSB
	} alu_op_t;

	function automatic logic [11:0] bcd8(input logic [7:0] t);
		logic [1:0] h;
		logic [7:0] r;
		logic [14:0] p;
		logic [3:0] tn;
		logic [7:0] o;
		h = (t >= 8'd200) ? 2'd2 : ((t >= 8'd100) ? 2'd1 : 2'd0);
		r = t - 8'(h) * 8'd100;
		p = 15'(r[6:0]) * 15'd205;
		tn = p[14:11];
		o = r - 8'(tn) * 8'd10;
		return {2'b00, h, tn, o[3:0]};
	endfunction
endpackage
`default_nettype wire

### rtl/core/c8_mem.sv
// Single-port byte memory with registered read data.
`default_nettype none
module c8_mem #(
	parameter int DEPTH = c8_pkg::MEM_BYTES,
	parameter int AW = c8_pkg::ADDR_W
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] addr,
	input wire logic [7:0] wdata,
	output logic [7:0] rdata
);
	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### rtl/core/c8_alu.sv
// Shared 16-bit arithmetic and compare unit.
`default_nettype none
module c8_alu (
	input wire c8_pkg::alu_op_t op,
	input wire logic [15:0] a,
	input wire logic [15:0] b,
	output logic [15:0] y,
	output logic eq,
	output logic ge
);
	always_comb begin
		case (op)
			c8_pkg::ALU_ADD: y = a + b;
			c8_pkg::ALU_SUB: y = a - b;
			c8_pkg::ALU_OR: y = a | b;
			c8_pkg::ALU_AND: y = a & b;
			c8_pkg::ALU_XOR: y = a ^ b;
			c8_pkg::ALU_PASSB: y = b;
			default: y = '0;
		endcase
	end

	assign eq = (a == b);
	assign ge = (a >= b);
endmodule
`default_nettype wire

### rtl/core/chip8_instruction_core.sv
// CHIP-8 instruction core: sequencer, register state and configuration port.
//
// After reset the core clears its 4096-byte memory, one byte per cycle, and
// accepts no transaction until the clear is done. Each transaction then runs
// through a sequencer that shares one ALU and one memory port; an executed
// instruction steps through two fetch reads, two register reads, execute,
// pc update and result. Fx33 adds the BCD memory writes, and Fx55/Fx65
// add a read step and a write step per register moved, up to 16. One
// transaction is in flight at a time; its result waits in an output register.
`default_nettype none
module chip8_instruction_core #(
	parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // address, data, random_byte, zero pad
	input wire logic [1:0] s_tuser, // kind
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [39:0] m_tdata, // program_counter, executed_opcode, status, read_data, pad
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int AW = c8_pkg::ADDR_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MWR, S_MRD, S_MRD_W, S_F_HI, S_F_LO, S_RVX,
		S_RVY, S_EXEC, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_PCU
	} state_t;

	state_t state_q;
	logic done_q;
	logic [AW-1:0] pc_q, start_q, base_q, clr_q, addr_q;
	logic [15:0] idx_q, op_q;
	logic [7:0] v_q [16];
	logic [AW-1:0] stk_q [STACK_DEPTH];
	logic [CW-1:0] cnt_q, cnt_m1;
	logic [7:0] delay_q, sound_q, data_q, rnd_q, vx_q, vy_q, rd_q;
	logic [1:0] status_q;
	logic [2:0] inc_q;
	logic [3:0] i_q;
	logic out_valid_q;
	logic [AW-1:0] out_pc_q;
	logic [15:0] out_op_q;
	logic [1:0] out_st_q;
	logic [7:0] out_rd_q;

	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0] mem_wdata, mem_rdata;
	c8_pkg::alu_op_t alu_op;
	logic [15:0] alu_a, alu_b, alu_y;
	logic alu_eq, alu_ge;
	logic [3:0] ridx;
	logic [11:0] bcd;
	logic [3:0] opx, opy, opn, nib;
	logic [7:0] kk;
	logic [AW-1:0] nnn;
	logic cfg_we;

	assign opx = op_q[11:8];
	assign opy = op_q[7:4];
	assign opn = op_q[3:0];
	assign nib = op_q[15:12];
	assign kk = op_q[7:0];
	assign nnn = op_q[11:0];
	assign cnt_m1 = cnt_q - CW'(1);
	assign bcd = c8_pkg::bcd8(vx_q);

	c8_mem #(.DEPTH(c8_pkg::MEM_BYTES), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	c8_alu u_alu (
		.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .eq(alu_eq), .ge(alu_ge)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_addr = pc_q;
		mem_wdata = '0;
		alu_op = c8_pkg::ALU_ADD;
		alu_a = '0;
		alu_b = '0;
		ridx = (state_q == S_RVY) ? opy : opx;
		if (state_q == S_RVX && nib == 4'hB) begin
			ridx = 4'h0;
		end else if (state_q == S_ST_RD) begin
			ridx = i_q;
		end
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
			end
			S_MWR: begin
				mem_we = 1'b1;
				mem_addr = addr_q;
				mem_wdata = data_q;
			end
			S_MRD: mem_addr = addr_q;
			S_F_LO: begin
				alu_a = 16'(pc_q);
				alu_b = 16'd1;
				mem_addr = alu_y[AW-1:0];
			end
			S_EXEC: begin
				case (nib)
					4'h3, 4'h4: begin
						alu_a = 16'(vx_q);
						alu_b = 16'(kk);
					end
					4'h5, 4'h9: begin
						alu_a = 16'(vx_q);
						alu_b = 16'(vy_q);
					end
					4'h7: begin
						alu_a = 16'(vx_q);
						alu_b = 16'(kk);
					end
					4'h8: begin
						alu_a = 16'(vx_q);
						alu_b = 16'(vy_q);
						case (opn)
							4'h0: alu_op = c8_pkg::ALU_PASSB;
							4'h1: alu_op = c8_pkg::ALU_OR;
							4'h2: alu_op = c8_pkg::ALU_AND;
							4'h3: alu_op = c8_pkg::ALU_XOR;
							4'h5: alu_op = c8_pkg::ALU_SUB;
							4'h7: begin
								alu_op = c8_pkg::ALU_SUB;
								alu_a = 16'(vy_q);
								alu_b = 16'(vx_q);
							end
							default: alu_op = c8_pkg::ALU_ADD;
						endcase
					end
					4'hB: begin
						alu_a = 16'(nnn);
						alu_b = 16'(vx_q);
					end
					4'hC: begin
						alu_op = c8_pkg::ALU_AND;
						alu_a = 16'(rnd_q);
						alu_b = 16'(kk);
					end
					default: begin
						alu_a = idx_q;
						alu_b = 16'(vx_q);
					end
				endcase
			end
			S_BCD: begin
				alu_a = idx_q;
				alu_b = 16'(i_q);
				mem_we = 1'b1;
				mem_addr = alu_y[AW-1:0];
				case (i_q[1:0])
					2'd0: mem_wdata = 8'(bcd[11:8]);
					2'd1: mem_wdata = 8'(bcd[7:4]);
					default: mem_wdata = 8'(bcd[3:0]);
				endcase
			end
			S_ST_WR: begin
				alu_a = idx_q;
				alu_b = 16'(i_q);
				mem_we = 1'b1;
				mem_addr = alu_y[AW-1:0];
				mem_wdata = vy_q;
			end
			S_LD_RD: begin
				alu_a = idx_q;
				alu_b = 16'(i_q);
				mem_addr = alu_y[AW-1:0];
			end
			S_PCU: begin
				alu_a = 16'(base_q);
				alu_b = 16'(inc_q);
			end
			default: ;
		endcase
	end

	assign cfg_we = psel && penable && pwrite && pready && (paddr == c8_pkg::REG_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q <= 1'b0;
			clr_q <= '0;
			pc_q <= c8_pkg::START_RESET;
			start_q <= c8_pkg::START_RESET;
			idx_q <= '0;
			for (int k = 0; k < 16; k++) begin
				v_q[k] <= '0;
			end
			cnt_q <= '0;
			delay_q <= '0;
			sound_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				start_q <= pwdata[AW-1:0];
				pc_q <= pwdata[AW-1:0];
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						addr_q <= s_tdata[11:0];
						data_q <= s_tdata[19:12];
						rnd_q <= s_tdata[27:20];
						op_q <= '0;
						status_q <= c8_pkg::ST_OK;
						rd_q <= '0;
						done_q <= 1'b0;
						case (s_tuser)
							c8_pkg::KIND_WRITE: state_q <= S_MWR;
							c8_pkg::KIND_READ: state_q <= S_MRD;
							c8_pkg::KIND_EXEC: state_q <= S_F_HI;
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_MWR: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MRD: state_q <= S_MRD_W;
				S_MRD_W: begin
					rd_q <= mem_rdata;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F_HI: state_q <= S_F_LO;
				S_F_LO: begin
					op_q[15:8] <= mem_rdata;
					state_q <= S_RVX;
				end
				S_RVX: begin
					op_q[7:0] <= mem_rdata;
					vx_q <= v_q[ridx];
					state_q <= S_RVY;
				end
				S_RVY: begin
					vy_q <= v_q[ridx];
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					base_q <= pc_q;
					inc_q <= 3'd2;
					state_q <= S_PCU;
					i_q <= '0;
					case (nib)
						4'h0: begin
							if (op_q != c8_pkg::OP_RET) begin
								status_q <= c8_pkg::ST_UNKNOWN;
							end else if (cnt_q == '0) begin
								status_q <= c8_pkg::ST_UNDERFLOW;
							end else begin
								cnt_q <= cnt_m1;
								base_q <= stk_q[cnt_m1[SW-1:0]];
							end
						end
						4'h1: begin
							base_q <= nnn;
							inc_q <= 3'd0;
						end
						4'h2: begin
							if (cnt_q != CW'(STACK_DEPTH)) begin
								stk_q[cnt_q[SW-1:0]] <= pc_q;
								cnt_q <= cnt_q + CW'(1);
							end else begin
								status_q <= c8_pkg::ST_OVERFLOW;
							end
							base_q <= nnn;
							inc_q <= 3'd0;
						end
						4'h3, 4'h5: if (alu_eq) inc_q <= 3'd4;
						4'h4, 4'h9: if (!alu_eq) inc_q <= 3'd4;
						4'h6: v_q[opx] <= kk;
						4'h7, 4'hC: v_q[opx] <= alu_y[7:0];
						4'h8: begin
							case (opn)
								4'h0, 4'h1, 4'h2, 4'h3: v_q[opx] <= alu_y[7:0];
								4'h4: begin
									v_q[opx] <= alu_y[7:0];
									v_q[15] <= 8'(alu_y[8]);
								end
								4'h5, 4'h7: begin
									v_q[opx] <= alu_y[7:0];
									v_q[15] <= 8'(alu_ge);
								end
								default: status_q <= c8_pkg::ST_UNKNOWN;
							endcase
						end
						4'hA: idx_q <= 16'(nnn);
						4'hB: begin
							base_q <= alu_y[AW-1:0];
							inc_q <= 3'd0;
						end
						4'hF: begin
							case (kk)
								8'h07: v_q[opx] <= delay_q;
								8'h15: delay_q <= vx_q;
								8'h18: sound_q <= vx_q;
								8'h1E: idx_q <= alu_y;
								8'h33: state_q <= S_BCD;
								8'h55: state_q <= S_ST_RD;
								8'h65: state_q <= S_LD_RD;
								default: status_q <= c8_pkg::ST_UNKNOWN;
							endcase
						end
						default: status_q <= c8_pkg::ST_UNKNOWN;
					endcase
				end
				S_BCD: begin
					i_q <= i_q + 4'd1;
					if (i_q == 4'd2) begin
						state_q <= S_PCU;
					end
				end
				S_ST_RD: begin
					vy_q <= v_q[ridx];
					state_q <= S_ST_WR;
				end
				S_ST_WR: begin
					i_q <= i_q + 4'd1;
					state_q <= (i_q == opx) ? S_PCU : S_ST_RD;
				end
				S_LD_RD: state_q <= S_LD_WR;
				S_LD_WR: begin
					v_q[i_q] <= mem_rdata;
					i_q <= i_q + 4'd1;
					state_q <= (i_q == opx) ? S_PCU : S_LD_RD;
				end
				S_PCU: begin
					pc_q <= alu_y[AW-1:0];
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (done_q && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
				out_pc_q <= pc_q;
				out_op_q <= op_q;
				out_st_q <= status_q;
				out_rd_q <= rd_q;
				done_q <= 1'b0;
				state_q <= S_IDLE;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE) && !done_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_rd_q, out_st_q, out_op_q, out_pc_q};
	assign prdata = 32'(start_q);
	assign pready = 1'b1;

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH)) else $error("return stack count out of range");
	a_stack_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
		(cnt_q + CW'(1) == $past(cnt_q))) else $error("return stack count jumped");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("second transaction taken");
`endif
endmodule
`default_nettype wire

### bench/tb_chip8_instruction_core.sv
// Testbench for the CHIP-8 instruction core: directed table, random programs, self-checking.
`timescale 1ns / 1ps
module tb_chip8_instruction_core;
	typedef struct packed {
		logic [11:0] pc;
		logic [15:0] op;
		logic [1:0] st;
		logic [7:0] rd;
	} core_result_t;

	typedef struct {
		logic [1:0] kind;
		logic [11:0] addr;
		logic [7:0] data;
		logic [7:0] rnd;
		bit typed;
		core_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0; // address, data, random_byte, zero pad
	logic [1:0] s_tuser = '0; // kind
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata; // program_counter, executed_opcode, status, read_data, pad
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	chip8_instruction_core i_dut (.*);

	always #2 clk = ~clk;

	// shadow state of the core
	logic [7:0] mem [c8_pkg::MEM_BYTES];
	logic [7:0] vreg [16];
	logic [15:0] idx;
	logic [11:0] pc;
	logic [11:0] stk [c8_pkg::STACK_DEPTH];
	int sp;
	logic [7:0] dtimer, stimer;

	core_result_t pending_results[$];
	int items_sent = 0;
	int errors = 0;
	bit calm = 0;
	bit held = 0;
	int hold_cnt = 0;

	task automatic shadow_reset();
		foreach (mem[i]) mem[i] = '0;
		foreach (vreg[i]) vreg[i] = '0;
		foreach (stk[i]) stk[i] = '0;
		idx = '0;
		pc = c8_pkg::START_RESET;
		sp = 0;
		dtimer = '0;
		stimer = '0;
	endtask

	task automatic step_core(input logic [1:0] k, input logic [11:0] a, input logic [7:0] d,
			input logic [7:0] r, output core_result_t res);
		logic [15:0] op;
		logic [3:0] x, y, n;
		logic [7:0] kk, va, vb, t;
		logic [11:0] nnn, nxt;
		logic [8:0] s;
		res = '0;
		case (k)
			c8_pkg::KIND_WRITE: mem[a] = d;
			c8_pkg::KIND_READ: res.rd = mem[a];
			c8_pkg::KIND_EXEC: begin
				op = {mem[pc], mem[pc + 12'd1]};
				x = op[11:8];
				y = op[7:4];
				n = op[3:0];
				kk = op[7:0];
				nnn = op[11:0];
				va = vreg[x];
				vb = vreg[y];
				nxt = pc + 12'd2;
				res.op = op;
				case (op[15:12])
					4'h0: begin
						if (op == c8_pkg::OP_RET) begin
							if (sp == 0) begin
								res.st = c8_pkg::ST_UNDERFLOW;
							end else begin
								sp--;
								nxt = stk[sp] + 12'd2;
								stk[sp] = '0;
							end
						end else begin
							res.st = c8_pkg::ST_UNKNOWN;
						end
					end
					4'h1: nxt = nnn;
					4'h2: begin
						if (sp < c8_pkg::STACK_DEPTH) begin
							stk[sp] = pc;
							sp++;
						end else begin
							res.st = c8_pkg::ST_OVERFLOW;
						end
						nxt = nnn;
					end
					4'h3: if (va == kk) nxt += 12'd2;
					4'h4: if (va != kk) nxt += 12'd2;
					4'h5: if (va == vb) nxt += 12'd2;
					4'h6: vreg[x] = kk;
					4'h7: vreg[x] = va + kk;
					4'h8: begin
						case (n)
							4'h0: vreg[x] = vb;
							4'h1: vreg[x] = va | vb;
							4'h2: vreg[x] = va & vb;
							4'h3: vreg[x] = va ^ vb;
							4'h4: begin
								s = {1'b0, va} + {1'b0, vb};
								vreg[x] = s[7:0];
								vreg[15] = {7'd0, s[8]};
							end
							4'h5: begin
								vreg[x] = va - vb;
								vreg[15] = {7'd0, va >= vb};
							end
							4'h7: begin
								vreg[x] = vb - va;
								vreg[15] = {7'd0, vb >= va};
							end
							default: res.st = c8_pkg::ST_UNKNOWN;
						endcase
					end
					4'h9: if (va != vb) nxt += 12'd2;
					4'hA: idx = {4'd0, nnn};
					4'hB: nxt = nnn + {4'd0, vreg[0]};
					4'hC: vreg[x] = r & kk;
					4'hD, 4'hE: res.st = c8_pkg::ST_UNKNOWN;
					default: begin
						case (kk)
							8'h07: vreg[x] = dtimer;
							8'h15: dtimer = va;
							8'h18: stimer = va;
							8'h1E: idx = idx + {8'd0, va};
							8'h33: begin
								t = va;
								mem[idx[11:0]] = t / 8'd100;
								mem[idx[11:0] + 12'd1] = (t / 8'd10) % 8'd10;
								mem[idx[11:0] + 12'd2] = t % 8'd10;
							end
							8'h55: for (int i = 0; i <= x; i++) mem[idx[11:0] + 12'(i)] = vreg[i];
							8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[idx[11:0] + 12'(i)];
							default: res.st = c8_pkg::ST_UNKNOWN;
						endcase
					end
				endcase
				pc = nxt;
			end
			default: ;
		endcase
		res.pc = pc;
	endtask

	task automatic send(input logic [1:0] k, input logic [11:0] a, input logic [7:0] d,
			input logic [7:0] r, input bit typed, input core_result_t typed_res);
		core_result_t res;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {4'd0, r, d, a};
		do @(posedge clk); while (!s_tready);
		step_core(k, a, d, r, res);
		pending_results.push_back(typed ? typed_res : res);
		items_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_start(input logic [11:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= c8_pkg::REG_START;
		pwdata <= {16'd0, 4'($urandom_range(0, 15)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pc = val;
	endtask

	function automatic logic [15:0] make_op(input logic [11:0] base, input int len);
		logic [11:0] tgt;
		logic [3:0] x, y;
		logic [7:0] kk;
		logic [7:0] fsub [9] = '{8'h07, 8'h15, 8'h18, 8'h1E, 8'h33, 8'h55, 8'h65, 8'h0A, 8'h29};
		tgt = base + 12'(2 * $urandom_range(0, len - 1));
		x = 4'($urandom);
		y = 4'($urandom);
		kk = 8'($urandom);
		case ($urandom_range(0, 15))
			0: case ($urandom_range(0, 3))
				0: return 16'h00E0;
				1: return {4'h0, 12'($urandom)};
				default: return c8_pkg::OP_RET;
			endcase
			1: return {4'h1, tgt};
			2: return {4'h2, tgt};
			3: return {4'h3, x, kk};
			4: return {4'h4, x, kk};
			5: return {4'h5, x, y, 4'($urandom)};
			6: return {4'h6, x, kk};
			7: return {4'h7, x, kk};
			8: return {4'h8, x, y, 4'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 7))};
			9: return {4'h9, x, y, 4'($urandom)};
			10: return {4'hA, 12'($urandom)};
			11: return {4'hB, tgt};
			12: return {4'hC, x, kk};
			13: return {4'hD, 12'($urandom)};
			14: return {4'hE, x, ($urandom_range(0, 2) == 0) ? kk : ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
			default: return {4'hF, x, ($urandom_range(0, 5) == 0) ? kk : fsub[$urandom_range(0, 8)]};
		endcase
	endfunction

	stim_row_t directed [20] = '{
		'{c8_pkg::KIND_READ, 12'h000, 8'h00, 8'h00, 1,
			'{12'h200, 16'h0000, c8_pkg::ST_OK, 8'h00}},
		'{2'd3, 12'hFFF, 8'hFF, 8'hFF, 1, '{12'h200, 16'h0000, c8_pkg::ST_OK, 8'h00}},
		'{c8_pkg::KIND_EXEC, 12'h000, 8'h00, 8'h00, 1,
			'{12'h202, 16'h0000, c8_pkg::ST_UNKNOWN, 8'h00}},
		'{c8_pkg::KIND_WRITE, 12'h202, 8'h00, 8'h00, 1,
			'{12'h202, 16'h0000, c8_pkg::ST_OK, 8'h00}},
		'{c8_pkg::KIND_WRITE, 12'h203, 8'hEE, 8'h00, 1,
			'{12'h202, 16'h0000, c8_pkg::ST_OK, 8'h00}},
		'{c8_pkg::KIND_EXEC, 12'h000, 8'h00, 8'h00, 1,
			'{12'h204, c8_pkg::OP_RET, c8_pkg::ST_UNDERFLOW, 8'h00}},
		'{c8_pkg::KIND_WRITE, 12'hFFF, 8'hFF, 8'h00, 1,
			'{12'h204, 16'h0000, c8_pkg::ST_OK, 8'h00}},
		'{c8_pkg::KIND_READ, 12'hFFF, 8'h00, 8'h00, 1,
			'{12'h204, 16'h0000, c8_pkg::ST_OK, 8'hFF}},
		'{c8_pkg::KIND_WRITE, 12'h204, 8'h6F, 8'h00, 0, '0},
		'{c8_pkg::KIND_WRITE, 12'h205, 8'hFF, 8'h00, 0, '0},
		'{c8_pkg::KIND_WRITE, 12'h206, 8'h8F, 8'h00, 0, '0},
		'{c8_pkg::KIND_WRITE, 12'h207, 8'hF4, 8'h00, 0, '0},
		'{c8_pkg::KIND_WRITE, 12'h208, 8'hC3, 8'h00, 0, '0},
		'{c8_pkg::KIND_WRITE, 12'h209, 8'hFF, 8'h00, 0, '0},
		'{c8_pkg::KIND_WRITE, 12'h20A, 8'hF3, 8'h00, 0, '0},
		'{c8_pkg::KIND_WRITE, 12'h20B, 8'h33, 8'h00, 0, '0},
		'{c8_pkg::KIND_EXEC, 12'h000, 8'h00, 8'h00, 0, '0},
		'{c8_pkg::KIND_EXEC, 12'h000, 8'h00, 8'h00, 0, '0},
		'{c8_pkg::KIND_EXEC, 12'h000, 8'h00, 8'hFF, 0, '0},
		'{c8_pkg::KIND_EXEC, 12'h000, 8'h00, 8'h00, 0, '0}
	};

	always @(posedge clk) begin
		core_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[11:0], m_tdata[27:12], m_tdata[29:28], m_tdata[37:30]};
			if (pending_results.size() == 0) begin
				$error("unexpected result pc=%h op=%h", got.pc, got.op);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.pc !== want.pc) begin
					$error("program_counter expected %h actual %h", want.pc, got.pc);
					errors++;
				end
				if (got.op !== want.op) begin
					$error("executed_opcode expected %h actual %h", want.op, got.op);
					errors++;
				end
				if (got.st !== want.st) begin
					$error("status expected %0d actual %0d", want.st, got.st);
					errors++;
				end
				if (got.rd !== want.rd) begin
					$error("read_data expected %h actual %h", want.rd, got.rd);
					errors++;
				end
			end
		end
		if (!held && items_sent >= 300) begin
			held = 1;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if (!m_tready) begin
			m_tready <= $urandom_range(0, 2) != 0;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			hold_cnt = $urandom_range(1, 5);
		end
	end

	initial begin
		logic [11:0] base;
		logic [15:0] op;
		logic [11:0] starts [4] = '{12'h000, 12'hFFF, 12'hFFE, 12'h200};
		int len, phase;
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send(directed[i].kind, directed[i].addr, directed[i].data, directed[i].rnd,
				directed[i].typed, directed[i].res);
		phase = 0;
		while (items_sent < 1100) begin
			if (items_sent >= 950) calm = 1;
			settle();
			base = (phase < 4) ? starts[phase] : 12'($urandom);
			write_start(base);
			len = $urandom_range(8, 24);
			for (int i = 0; i < len; i++) begin
				op = make_op(base, len);
				send(c8_pkg::KIND_WRITE, base + 12'(2 * i), op[15:8], 8'($urandom), 0, '0);
				send(c8_pkg::KIND_WRITE, base + 12'(2 * i + 1), op[7:0], 8'($urandom), 0, '0);
			end
			repeat ($urandom_range(30, 50)) begin
				case ($urandom_range(0, 19))
					0: send(c8_pkg::KIND_WRITE, 12'($urandom), 8'($urandom), 8'($urandom), 0, '0);
					1: send(c8_pkg::KIND_READ, 12'($urandom), 8'($urandom), 8'($urandom), 0, '0);
					2: send(2'd3, 12'($urandom), 8'($urandom), 8'($urandom), 0, '0);
					default: send(c8_pkg::KIND_EXEC, 12'($urandom), 8'($urandom), 8'($urandom),
						0, '0);
				endcase
			end
			phase++;
		end
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end
endmodule

### filelist.f
rtl/core/c8_pkg.sv
rtl/core/c8_mem.sv
rtl/core/c8_alu.sv
rtl/core/chip8_instruction_core.sv
bench/tb_chip8_instruction_core.sv
